@@ design/charlieplex_led_scanner_top_macros.svh @@
// ----------------------------------------------------------------------------
// Charlieplex LED scanner assertion macros
// Shared concurrent assertion forms for the scanner's checks.
// ----------------------------------------------------------------------------
`ifndef CHARLIEPLEX_LED_SCANNER_TOP_MACROS_SVH
`define CHARLIEPLEX_LED_SCANNER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

@@ design/cls_pkg.sv @@
// ----------------------------------------------------------------------------
// Charlieplex LED scanner package
// Types, register indexes, pin map defaults and the pin lookup function.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

    localparam int PORT_W     = 24;
    localparam int PIN_W      = 5;
    localparam int MAP_LO_W   = 30;
    localparam int MAP_HI_W   = 25;
    localparam int CMD_W      = 2;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MAP_LO_W-1:0] PIN_MAP_LOW_RESET  = 30'd343083040;
    localparam logic [MAP_HI_W-1:0] PIN_MAP_HIGH_RESET = 25'd16201099;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_FLIP = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIN_MAP_LOW  = 2'd0,
        CFG_PIN_MAP_HIGH = 2'd1
    } t_cfg_index;

    // One-hot port bit of a line. Positions beyond the port give no bit.
    function automatic logic [PORT_W-1:0] pin_bit(
        input logic [POS_W-1:0]    line,
        input logic [MAP_LO_W-1:0] map_lo,
        input logic [MAP_HI_W-1:0] map_hi
    );
        logic [PIN_W-1:0] pos;
        logic             hit;
        hit = 1'b1;
        case (line)
            4'd0:    pos = map_lo[4:0];
            4'd1:    pos = map_lo[9:5];
            4'd2:    pos = map_lo[14:10];
            4'd3:    pos = map_lo[19:15];
            4'd4:    pos = map_lo[24:20];
            4'd5:    pos = map_lo[29:25];
            4'd6:    pos = map_hi[4:0];
            4'd7:    pos = map_hi[9:5];
            4'd8:    pos = map_hi[14:10];
            4'd9:    pos = map_hi[19:15];
            4'd10:   pos = map_hi[24:20];
            default: begin
                pos = '0;
                hit = 1'b0;
            end
        endcase
        if (hit && (pos < PIN_W'(PORT_W))) begin
            pin_bit = PORT_W'(1) << pos;
        end else begin
            pin_bit = '0;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/charlieplex_led_scanner_top.sv @@
// An accepted item is held in the input register and moves into the result register
// once the result register is empty or being emptied.
// Throughput: one item per cycle while the receiver takes results, set by the single
// input register and the single result register with the work between them.
// Reset (synchronous, active low) clears both image buffers, the buffer
// select, the scan counters and the port vectors; the pin map takes defaults.
// ----------------------------------------------------------------------------
// Charlieplex LED scanner top level
// Scans a double-buffered image onto a charlieplexed matrix, one LED a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module charlieplex_led_scanner_top #(
    parameter int GRID_SIZE = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [cls_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [cls_pkg::POS_W-1:0]     i_row,
    input  wire logic [cls_pkg::POS_W-1:0]     i_col,
    input  wire logic                          i_led_on,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [cls_pkg::PORT_W-1:0]         o_drive_enable,
    output logic [cls_pkg::PORT_W-1:0]         o_drive_level,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cls_pkg::MAP_LO_W-1:0]  i_cfg_data
);

    import cls_pkg::*;

    `include "charlieplex_led_scanner_top_macros.svh"

    // Lines run from 0 to GRID_SIZE, columns from 0 to GRID_SIZE-1.
    localparam int NUM_WORDS = GRID_SIZE + 1;
    localparam int LINE_W    = $clog2(GRID_SIZE + 1);
    localparam int COL_W     = $clog2(GRID_SIZE);

    typedef logic [GRID_SIZE-1:0] t_word;

    // Input register: the accepted item waits here until the result register can take it.
    logic                 r_s1_valid;
    t_cmd                 r_s1_cmd;
    logic [POS_W-1:0]     r_s1_row;
    logic [POS_W-1:0]     r_s1_col;
    logic                 r_s1_led_on;

    // Result register. The port vectors double as the last pin state, so a
    // non-tick item simply repeats them.
    logic                 r_out_valid;
    logic [PORT_W-1:0]    r_last_enable;
    logic [PORT_W-1:0]    r_last_level;
    logic [PORT_W-1:0]    n_last_enable;
    logic [PORT_W-1:0]    n_last_level;

    // Image buffers and scan state.
    t_word                r_store_a [NUM_WORDS];
    t_word                r_store_b [NUM_WORDS];
    t_word                n_store_a [NUM_WORDS];
    t_word                n_store_b [NUM_WORDS];
    logic                 r_front_select;
    logic                 n_front_select;
    logic [LINE_W-1:0]    r_scan_line;
    logic [LINE_W-1:0]    n_scan_line;
    logic [COL_W-1:0]     r_scan_column;
    logic [COL_W-1:0]     n_scan_column;

    logic [MAP_LO_W-1:0]  r_pin_map_low;
    logic [MAP_HI_W-1:0]  r_pin_map_high;

    logic                 w_adv;
    logic                 w_set_ok;
    logic [LINE_W-1:0]    w_set_word;
    logic [COL_W-1:0]     w_set_bit;
    t_word                w_front_word;
    logic                 w_lit;
    logic [PORT_W-1:0]    w_line_bit;
    logic [PORT_W-1:0]    w_col_bit;
    logic [PORT_W-1:0]    w_tick_enable;
    logic [PORT_W-1:0]    w_tick_level;

    // Terms used by the checks at the end of the module.
    logic                 w_non_tick;
    logic [2*PORT_W-1:0]  w_pins;
    logic                 w_scan_ok;
    logic                 w_out_stall;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign w_adv       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid    = r_out_valid;
    assign o_drive_enable = r_last_enable;
    assign o_drive_level  = r_last_level;

    // A set outside the grid is dropped. Diagonal LEDs live in the last word.
    assign w_set_ok   = (r_s1_row < POS_W'(GRID_SIZE)) && (r_s1_col < POS_W'(GRID_SIZE));
    assign w_set_word = (r_s1_row == r_s1_col) ? LINE_W'(GRID_SIZE) : r_s1_col[LINE_W-1:0];
    assign w_set_bit  = r_s1_row[COL_W-1:0];

    // Tick: the scan line is always driven, the column line only when the
    // front image has that bit lit. On the last line the polarity flips.
    assign w_front_word  = r_front_select ? r_store_b[r_scan_line] : r_store_a[r_scan_line];
    assign w_lit         = w_front_word[r_scan_column];
    assign w_line_bit    = pin_bit(POS_W'(r_scan_line), r_pin_map_low, r_pin_map_high);
    assign w_col_bit     = pin_bit(POS_W'(r_scan_column), r_pin_map_low, r_pin_map_high);
    assign w_tick_enable = w_line_bit | (w_lit ? w_col_bit : '0);
    assign w_tick_level  = (r_scan_line != LINE_W'(GRID_SIZE))
                         ? (w_tick_enable & ~w_line_bit)
                         : (w_tick_enable & w_line_bit);

    always_comb begin
        n_store_a      = r_store_a;
        n_store_b      = r_store_b;
        n_front_select = r_front_select;
        n_scan_line    = r_scan_line;
        n_scan_column  = r_scan_column;
        n_last_enable  = r_last_enable;
        n_last_level   = r_last_level;
        if (w_adv) begin
            case (r_s1_cmd)
                CMD_TICK: begin
                    n_last_enable = w_tick_enable;
                    n_last_level  = w_tick_level;
                    if (r_scan_column == COL_W'(GRID_SIZE - 1)) begin
                        n_scan_column = '0;
                        if (r_scan_line == LINE_W'(GRID_SIZE)) begin
                            n_scan_line = '0;
                        end else begin
                            n_scan_line = r_scan_line + LINE_W'(1);
                        end
                    end else begin
                        n_scan_column = r_scan_column + COL_W'(1);
                    end
                end
                CMD_SET: begin
                    // The back buffer is the one not on show.
                    for (int i = 0; i < NUM_WORDS; i++) begin
                        if (w_set_ok && (w_set_word == LINE_W'(i))) begin
                            if (r_front_select) begin
                                n_store_a[i][w_set_bit] = r_s1_led_on;
                            end else begin
                                n_store_b[i][w_set_bit] = r_s1_led_on;
                            end
                        end
                    end
                end
                CMD_FLIP: begin
                    n_front_select = !r_front_select;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_front_select <= 1'b0;
            r_scan_line    <= '0;
            r_scan_column  <= '0;
            r_last_enable  <= '0;
            r_last_level   <= '0;
            r_pin_map_low  <= PIN_MAP_LOW_RESET;
            r_pin_map_high <= PIN_MAP_HIGH_RESET;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_store_a[i] <= '0;
                r_store_b[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_front_select <= n_front_select;
            r_scan_line    <= n_scan_line;
            r_scan_column  <= n_scan_column;
            r_last_enable  <= n_last_enable;
            r_last_level   <= n_last_level;
            r_store_a      <= n_store_a;
            r_store_b      <= n_store_b;
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PIN_MAP_LOW:  r_pin_map_low  <= i_cfg_data;
                    CFG_PIN_MAP_HIGH: r_pin_map_high <= i_cfg_data[MAP_HI_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_cmd    <= t_cmd'(i_cmd);
            r_s1_row    <= i_row;
            r_s1_col    <= i_col;
            r_s1_led_on <= i_led_on;
        end
    end

    assign w_non_tick  = w_adv && (r_s1_cmd != CMD_TICK);
    assign w_pins      = {r_last_enable, r_last_level};
    assign w_scan_ok   = (r_scan_column <= COL_W'(GRID_SIZE - 1))
                      && (r_scan_line <= LINE_W'(GRID_SIZE));
    assign w_out_stall = r_s1_valid && r_out_valid && !i_out_ready;

    // An item other than a tick (a set, a flip or an unused command) never disturbs the pins.
    `CLS_ASSERT_NEXT(a_non_tick_holds, i_clk, i_rst_n, w_non_tick, $stable(w_pins))
    // A driven level is only ever on a pin that is enabled.
    `CLS_ASSERT_SAME(a_level_in_enable, i_clk, i_rst_n, 1'b1, (o_drive_level & ~o_drive_enable) == '0)
    // The scan counters stay inside the grid.
    `CLS_ASSERT_SAME(a_scan_in_range, i_clk, i_rst_n, 1'b1, w_scan_ok)
    // Input is refused only while both registers are full and the output stalls.
    `CLS_ASSERT_SAME(a_ready_low_cause, i_clk, i_rst_n, !o_in_ready, w_out_stall)

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Charlieplex LED scanner testbench
// Drives set, flip and tick items through the scanner under several pin maps
// and idling patterns. A scanner model kept alongside works out the port
// vectors that each item should leave, and every result item is checked
// against them in order.
// ----------------------------------------------------------------------------

module tb_top;

    import cls_pkg::*;

    localparam int GRID      = 10;
    localparam int LATENCY   = 2;
    localparam int SHOW_MAX  = 30;

    // The package has no name for the fourth command code or the spare
    // register indexes; both must leave the scanner untouched.
    localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

    typedef struct packed {
        logic [PORT_W-1:0] enable;
        logic [PORT_W-1:0] level;
    } t_pins;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts known.
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_cmd       = CMD_TICK;
    logic [POS_W-1:0]      i_row       = '0;
    logic [POS_W-1:0]      i_col       = '0;
    logic                  i_led_on    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PORT_W-1:0]     o_drive_enable;
    logic [PORT_W-1:0]     o_drive_level;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PIN_MAP_LOW;
    logic [MAP_LO_W-1:0]   i_cfg_data  = '0;

    always #5 i_clk = ~i_clk;

    charlieplex_led_scanner_top #(
        .GRID_SIZE (GRID)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_led_on       (i_led_on),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_drive_enable (o_drive_enable),
        .o_drive_level  (o_drive_level),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Scanner model state. It mirrors the reset state of the block: both
    // images blank, image A shown, scan at line 0 column 0, port idle and
    // the default pin map.
    // ------------------------------------------------------------------
    logic [GRID-1:0]       img_a [0:GRID];
    logic [GRID-1:0]       img_b [0:GRID];
    logic                  show_b;
    logic [POS_W-1:0]      scan_ln;
    logic [POS_W-1:0]      scan_col;
    logic [PORT_W-1:0]     port_en;
    logic [PORT_W-1:0]     port_lvl;
    logic [MAP_LO_W-1:0]   map_lo;
    logic [MAP_HI_W-1:0]   map_hi;

    // Port vectors still owed by the block, oldest first.
    t_pins                 pins_due [$];

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int                    idle_pct  = 0;
    int                    stall_pct = 0;

    int                    mismatches = 0;
    int                    n_items    = 0;
    int                    n_ticks    = 0;
    int                    n_lit      = 0;
    int                    n_writes   = 0;

    // One-hot port bit of a scan line under the current pin map. A position
    // beyond the 24-bit port drives nothing.
    function automatic logic [PORT_W-1:0] line_pin_of(input logic [POS_W-1:0] line);
        int pos;
        if (line < 6) begin
            pos = int'((map_lo >> (PIN_W * line)) & 31);
        end else begin
            pos = int'((map_hi >> (PIN_W * (line - 6))) & 31);
        end
        return (pos < PORT_W) ? (PORT_W'(1) << pos) : '0;
    endfunction

    // Applies one item to the model and queues the port vectors it leaves.
    task automatic scan_predict(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                                input logic [POS_W-1:0] col, input logic led_on);
        logic [GRID-1:0]   word;
        logic              lit;
        logic [PORT_W-1:0] line_pin;
        int                w;
        case (cmd)
            CMD_TICK: begin
                word     = show_b ? img_b[scan_ln] : img_a[scan_ln];
                lit      = word[scan_col];
                line_pin = line_pin_of(scan_ln);
                port_en  = line_pin | (lit ? line_pin_of(scan_col) : '0);
                // Column words sink through the line pin; the diagonal word
                // reverses the polarity and sources from the line pin.
                if (scan_ln != GRID) begin
                    port_lvl = port_en & ~line_pin;
                end else begin
                    port_lvl = port_en & line_pin;
                end
                if (scan_col == GRID - 1) begin
                    scan_col = '0;
                    scan_ln  = (scan_ln == GRID) ? '0 : scan_ln + 1'b1;
                end else begin
                    scan_col = scan_col + 1'b1;
                end
                n_ticks++;
                if (lit) begin
                    n_lit++;
                end
            end
            CMD_SET: begin
                if (row < GRID && col < GRID) begin
                    w = (row == col) ? GRID : int'(col);
                    if (show_b) begin
                        img_a[w][row] = led_on;
                    end else begin
                        img_b[w][row] = led_on;
                    end
                end
            end
            CMD_FLIP: begin
                show_b = ~show_b;
            end
            default: begin
            end
        endcase
        pins_due.push_back('{enable: port_en, level: port_lvl});
    endtask

    task automatic report_mismatch(input string what, input logic [PORT_W-1:0] got,
                                   input logic [PORT_W-1:0] want);
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
            $display("%0t ns: %s: got %06h, wanted %06h", $time, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker. Every result item accepted at a rising edge is held
    // against the oldest outstanding expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pins_due.size() == 0) begin
                report_mismatch("result item with nothing outstanding", o_drive_enable, '0);
            end else begin
                if (o_drive_enable !== pins_due[0].enable) begin
                    report_mismatch("drive_enable", o_drive_enable, pins_due[0].enable);
                end
                if (o_drive_level !== pins_due[0].level) begin
                    report_mismatch("drive_level", o_drive_level, pins_due[0].level);
                end
                void'(pins_due.pop_front());
            end
        end
    end

    // The receiver stalls at random, re-decided at every falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Item and register traffic. All of these are entered and left at a
    // falling edge. The item valid is left high on return so that the next item can
    // follow without a gap; settle() and the idle spells before an item lower it.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col, input logic led_on);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_row      <= row;
        i_col      <= col;
        i_led_on   <= led_on;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        scan_predict(cmd, row, col, led_on);
        n_items++;
        @(negedge i_clk);
    endtask

    // Register writes leave the valid high as well; the caller lowers it
    // once the last write of a group has gone through.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_LO_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_PIN_MAP_LOW:  map_lo = data;
            CFG_PIN_MAP_HIGH: map_hi = data[MAP_HI_W-1:0];
            default: begin
            end
        endcase
        n_writes++;
        @(negedge i_clk);
    endtask

    task automatic load_pin_map(input logic [MAP_LO_W-1:0] lo, input logic [MAP_LO_W-1:0] hi);
        write_reg(CFG_PIN_MAP_LOW, lo);
        write_reg(CFG_PIN_MAP_HIGH, hi);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until the block has handed back everything,
    // then lets the pipeline run dry so that a register write finds it idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pins_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // A random pin map, mostly on real port bits with the odd position
    // beyond the port. The top bits of the word are random too: the high
    // register must ignore them.
    function automatic logic [MAP_LO_W-1:0] random_map();
        logic [MAP_LO_W-1:0] m;
        m = '0;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(9) == 0) begin
                m |= MAP_LO_W'($urandom_range(PORT_W, 31)) << (PIN_W * i);
            end else begin
                m |= MAP_LO_W'($urandom_range(0, PORT_W - 1)) << (PIN_W * i);
            end
        end
        return m;
    endfunction

    // Random traffic. Most items are ticks and in-range sets, with the odd
    // flip so that drawn pictures reach the screen; the remainder are sets
    // off the grid and the spare command code.
    task automatic random_items(input int count);
        int               pick;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             led_on;
        for (int n = 0; n < count; n++) begin
            pick   = $urandom_range(99);
            row    = POS_W'($urandom_range(0, GRID - 1));
            col    = POS_W'($urandom_range(0, GRID - 1));
            led_on = ($urandom_range(9) < 7);
            if (pick < 55) begin
                send_item(CMD_TICK, POS_W'($urandom), POS_W'($urandom), 1'($urandom));
            end else if (pick < 85) begin
                send_item(CMD_SET, row, col, led_on);
            end else if (pick < 90) begin
                send_item(CMD_FLIP, POS_W'($urandom), POS_W'($urandom), 1'($urandom));
            end else if (pick < 95) begin
                if ($urandom_range(1)) begin
                    row = POS_W'($urandom_range(GRID, 15));
                end else begin
                    col = POS_W'($urandom_range(GRID, 15));
                end
                send_item(CMD_SET, row, col, led_on);
            end else begin
                send_item(CMD_SPARE, POS_W'($urandom), POS_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A blank image scans only the line pins, each driven low.
    task automatic test_blank_scan();
        repeat (3) send_item(CMD_TICK, '0, '0, 1'b0);
    endtask

    // Draws into the back image, checks that nothing shows until a flip,
    // and that sets off the grid and the spare command change nothing.
    task automatic test_set_and_flip();
        // Row 1 of column 0 lights at line 0, column 1 of the scan.
        send_item(CMD_SET, 4'd1, 4'd0, 1'b1);
        send_item(CMD_TICK, '0, '0, 1'b0);
        send_item(CMD_SET, 4'd15, 4'd15, 1'b1);
        send_item(CMD_SET, 4'd10, 4'd2, 1'b1);
        send_item(CMD_SET, 4'd5, 4'd12, 1'b1);
        send_item(CMD_SPARE, 4'hF, 4'hF, 1'b1);
        send_item(CMD_FLIP, '0, '0, 1'b0);
        // The scan has moved on, so draw further along line 0 as well.
        send_item(CMD_SET, 4'd6, 4'd0, 1'b1);
        send_item(CMD_SET, 4'd9, 4'd9, 1'b1);
        send_item(CMD_FLIP, '0, '0, 1'b0);
        send_item(CMD_SET, 4'd6, 4'd0, 1'b1);
        send_item(CMD_SET, 4'd7, 4'd0, 1'b1);
        send_item(CMD_SET, 4'd7, 4'd0, 1'b0);
        send_item(CMD_FLIP, '0, '0, 1'b0);
        repeat (8) send_item(CMD_TICK, 4'hF, 4'hF, 1'b1);
    endtask

    // Pin maps at their extremes: every line on bit 0, every line beyond
    // the port, every line on the top port bit, and a spare register index.
    task automatic test_pin_map_extremes();
        settle();
        load_pin_map('0, '0);
        random_items(120);
        settle();
        write_reg(CFG_SPARE, '0);
        load_pin_map('1, '1);
        random_items(120);
        settle();
        load_pin_map({6{5'd23}}, {6{5'd23}});
        random_items(120);
    endtask

    // Long random runs, one per idling pattern, each under a fresh pin map.
    task automatic test_random_traffic();
        int idle_set  [4] = '{0, 45, 0, 23};
        int stall_set [4] = '{0, 0, 45, 23};
        for (int p = 0; p < 4; p++) begin
            settle();
            load_pin_map(random_map(), random_map());
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            random_items(420);
        end
        // Finish on the default map once more, with no idling and no stalls.
        settle();
        load_pin_map(PIN_MAP_LOW_RESET, MAP_LO_W'(PIN_MAP_HIGH_RESET));
        idle_pct  = 0;
        stall_pct = 0;
        random_items(100);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i <= GRID; i++) begin
            img_a[i] = '0;
            img_b[i] = '0;
        end
        show_b   = 1'b0;
        scan_ln  = '0;
        scan_col = '0;
        port_en  = '0;
        port_lvl = '0;
        map_lo   = PIN_MAP_LOW_RESET;
        map_hi   = PIN_MAP_HIGH_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_blank_scan();
        test_set_and_flip();
        test_pin_map_extremes();
        test_random_traffic();

        settle();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (pins_due.size() != 0) begin
            report_mismatch("result items never delivered", PORT_W'(pins_due.size()), '0);
        end

        $display("Sent %0d items (%0d ticks, %0d with an LED lit) and %0d register writes.",
                 n_items, n_ticks, n_lit, n_writes);
        $display("Pin maps covered: default, zero, beyond port, top bit and random; "
                 , "%0d mismatches.", mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Run stopped by the watchdog with %0d result items outstanding.",
                 pins_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
